>>> design/qclt_pkg.sv
// types, codes and constants shared by the command line tokenizer
package qclt_pkg;

	localparam int CHAR_W     = 8;
	localparam int WORDS_W    = 8;
	localparam int STATE_W    = 3;
	localparam int KIND_W     = 2;
	localparam int OBUF_DEPTH = 4;
	localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);
	localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

	// count stops at the smaller of 255 and the field limit
	localparam logic [WORDS_W-1:0] WORD_LIMIT = 8'd255;

	// parse states
	localparam logic [STATE_W-1:0] ST_BETWEEN = 3'd0;
	localparam logic [STATE_W-1:0] ST_DQ      = 3'd1;
	localparam logic [STATE_W-1:0] ST_DQ_ESC  = 3'd2;
	localparam logic [STATE_W-1:0] ST_SQ      = 3'd3;
	localparam logic [STATE_W-1:0] ST_WORD    = 3'd4;
	localparam logic [STATE_W-1:0] ST_ESC     = 3'd5;

	// result kinds
	localparam logic [KIND_W-1:0] K_BYTE   = 2'd0;
	localparam logic [KIND_W-1:0] K_EOW    = 2'd1;
	localparam logic [KIND_W-1:0] K_ACCEPT = 2'd2;
	localparam logic [KIND_W-1:0] K_REJECT = 2'd3;

	// characters of interest
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5c;
	localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
	localparam logic [CHAR_W-1:0] CH_LC_T   = 8'h74;
	localparam logic [CHAR_W-1:0] CH_LC_N   = 8'h6e;

	typedef struct packed {
		logic              func;
		logic [CHAR_W-1:0] char_in;
	} qclt_in_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [CHAR_W-1:0]  char_out;
		logic [WORDS_W-1:0] words;
		logic               last;
	} qclt_out_t;

	// up to two results produced by one line item
	typedef struct packed {
		logic      v0;
		logic      v1;
		qclt_out_t r0;
		qclt_out_t r1;
	} qclt_push_t;

endpackage

>>> design/qclt_step.sv
// next-state and result logic for one line item
module qclt_step (
	input  logic [qclt_pkg::STATE_W-1:0] state,
	input  logic [qclt_pkg::WORDS_W-1:0] count,
	input  qclt_pkg::qclt_in_t           item,
	output logic [qclt_pkg::STATE_W-1:0] state_nxt,
	output logic [qclt_pkg::WORDS_W-1:0] count_nxt,
	output qclt_pkg::qclt_push_t         push
);
	import qclt_pkg::*;

	logic              is_ws;
	logic              inc;
	logic [CHAR_W-1:0] c;
	logic [WORDS_W-1:0] counted;
	logic [KIND_W-1:0] kind0;
	logic [KIND_W-1:0] kind1;
	logic [CHAR_W-1:0] ch0;
	logic [CHAR_W-1:0] ch1;
	logic              v0;
	logic              v1;

	assign c     = item.char_in;
	assign is_ws = (c == CH_SPACE) || (c == CH_TAB);

	always_comb begin
		state_nxt = state;
		inc   = 1'b0;
		v0    = 1'b0;
		v1    = 1'b0;
		kind0 = K_BYTE;
		kind1 = K_BYTE;
		ch0   = c;
		ch1   = c;
		if (item.func) begin
			state_nxt = ST_BETWEEN;
			v0 = 1'b1;
			if (state == ST_WORD) begin
				inc   = 1'b1;
				kind0 = K_EOW;
				v1    = 1'b1;
				kind1 = K_ACCEPT;
			end else if (state == ST_BETWEEN) begin
				kind0 = K_ACCEPT;
			end else begin
				kind0 = K_REJECT;
			end
		end else begin
			unique case (state)
				ST_DQ: begin
					if (c == CH_DQUOTE) state_nxt = ST_WORD;
					else if (c == CH_BSLASH) state_nxt = ST_DQ_ESC;
					else v0 = 1'b1;
				end
				ST_DQ_ESC: begin
					state_nxt = ST_DQ;
					v0 = 1'b1;
					// escaped t or n keeps its backslash
					if (c == CH_LC_T || c == CH_LC_N) begin
						ch0 = CH_BSLASH;
						v1  = 1'b1;
					end
				end
				ST_SQ: begin
					if (c == CH_SQUOTE) state_nxt = ST_WORD;
					else v0 = 1'b1;
				end
				ST_ESC: begin
					state_nxt = ST_WORD;
					v0 = 1'b1;
				end
				ST_WORD: begin
					if (is_ws) begin
						inc   = 1'b1;
						v0    = 1'b1;
						kind0 = K_EOW;
						state_nxt = ST_BETWEEN;
					end else if (c == CH_BSLASH) state_nxt = ST_ESC;
					else if (c == CH_DQUOTE) state_nxt = ST_DQ;
					else if (c == CH_SQUOTE) state_nxt = ST_SQ;
					else v0 = 1'b1;
				end
				default: begin
					if (is_ws) state_nxt = state;
					else if (c == CH_BSLASH) state_nxt = ST_ESC;
					else if (c == CH_DQUOTE) state_nxt = ST_DQ;
					else if (c == CH_SQUOTE) state_nxt = ST_SQ;
					else begin
						state_nxt = ST_WORD;
						v0 = 1'b1;
					end
				end
			endcase
		end
	end

	assign counted   = (inc && count < WORD_LIMIT) ? count + 1'b1 : count;
	assign count_nxt = item.func ? '0 : counted;

	always_comb begin
		push.v0          = v0;
		push.v1          = v1;
		push.r0.kind     = kind0;
		push.r0.char_out = (kind0 == K_BYTE) ? ch0 : '0;
		push.r0.words    = counted;
		push.r0.last     = !v1;
		push.r1.kind     = kind1;
		push.r1.char_out = (kind1 == K_BYTE) ? ch1 : '0;
		push.r1.words    = counted;
		push.r1.last     = 1'b1;
	end

endmodule

>>> design/qclt_obuf.sv
// small result queue: takes up to two results a cycle, hands out one when result_ready is high
module qclt_obuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qclt_pkg::qclt_push_t push,
	output logic                 space_ok,
	output logic                 result_valid,
	input  logic                 result_ready,
	output qclt_pkg::qclt_out_t  result
);
	import qclt_pkg::*;

	qclt_out_t             entry_q [OBUF_DEPTH];
	logic [OBUF_PTR_W-1:0] wr_ptr_q;
	logic [OBUF_PTR_W-1:0] rd_ptr_q;
	logic [OBUF_CNT_W-1:0] count_q;
	logic [OBUF_PTR_W-1:0] wr_ptr_1;
	logic                  pop;
	logic [OBUF_CNT_W-1:0] n_push;

	assign wr_ptr_1     = wr_ptr_q + 1'b1;
	assign result_valid = (count_q != '0);
	assign result       = entry_q[rd_ptr_q];
	assign pop          = result_valid && result_ready;
	assign n_push       = OBUF_CNT_W'(push.v0) + OBUF_CNT_W'(push.v1);
	// room for the worst case of two results
	assign space_ok     = (count_q <= OBUF_CNT_W'(OBUF_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.v0) entry_q[wr_ptr_q] <= push.r0;
		if (push.v1) entry_q[wr_ptr_1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OBUF_PTR_W'(n_push);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + n_push - OBUF_CNT_W'(pop);
		end
	end

endmodule

>>> design/quoted_command_line_tokenizer_core.sv
// Splits a command line into words with quotes and escapes honored.
// Input channel item_valid/item_ready/item carries one line byte or an
// end-of-line mark per transaction. Output channel result_valid/
// result_ready/result carries word bytes, end-of-word marks and a final
// accepted or rejected result; last flags the final result of each item.
// An item is captured in an input register and decoded, once the queue
// has room, into zero, one or two results for a four-entry result queue.
// Throughput: one item per cycle while results drain at one per cycle;
// an item giving two results (escaped t or n in double quotes, end of
// line inside a word) sends them out one after the other, so the queue
// port sets the long-run rate at one result per cycle.
// When the receiver stalls, the queue fills and item_ready drops once
// fewer than two free entries remain with an item waiting to decode.
// Reset clears the parse state to between words, the word count to zero
// and empties the queue.
module quoted_command_line_tokenizer_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  qclt_pkg::qclt_in_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output qclt_pkg::qclt_out_t result
);
	import qclt_pkg::*;

	logic                 valid_s1;
	qclt_in_t             item_s1;
	logic [STATE_W-1:0]   state_q;
	logic [WORDS_W-1:0]   count_q;
	logic [STATE_W-1:0]   state_nxt;
	logic [WORDS_W-1:0]   count_nxt;
	qclt_push_t           push_raw;
	qclt_push_t           push;
	logic                 space_ok;
	logic                 advance;

	assign advance    = valid_s1 && space_ok;
	assign item_ready = !valid_s1 || space_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BETWEEN;
			count_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			count_q <= count_nxt;
		end
	end

	qclt_step u_step (
		.state     (state_q),
		.count     (count_q),
		.item      (item_s1),
		.state_nxt (state_nxt),
		.count_nxt (count_nxt),
		.push      (push_raw)
	);

	// only a decoded transaction writes the queue
	always_comb begin
		push    = push_raw;
		push.v0 = push_raw.v0 && advance;
		push.v1 = push_raw.v1 && advance;
	end

	qclt_obuf u_obuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.space_ok     (space_ok),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0)
		else $error("second result written without a first");

	a_line_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.func) |=> (state_q == ST_BETWEEN && count_q == '0))
		else $error("end of line did not clear parse state");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> valid_s1)
		else $error("input stalled with no pending transaction");

	a_line_result_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.kind == K_ACCEPT || result.kind == K_REJECT))
		|-> result.last)
		else $error("line result not flagged last");

endmodule
